// ===== hdl/cfla_pkg.sv =====
// cfla_pkg: shared types and constants of the coalescing free-list allocator
// used by cfla_alu and coalescing_free_list_allocator; depends on nothing else
`default_nettype none

package cfla_pkg;

    // default sizing
    localparam int MAX_REGIONS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;

    // arena span loaded at reset
    localparam logic [31:0] ARENA_RESET = 32'd65536;

    // field widths on the stream ports
    localparam int FIELD_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 2 * FIELD_W;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - FIELD_W - STATUS_W - COUNT_W;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NO_FIT = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    // request kinds carried on s_tuser
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_SCAN,
        ST_A_UPD,
        ST_F_END,
        ST_F_SCAN,
        ST_F_HEAD,
        ST_F_PEND,
        ST_F_DECIDE,
        ST_F_MERGE3,
        ST_DN_START,
        ST_DN_WR,
        ST_UP_START,
        ST_UP_WR,
        ST_UP_FIN,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/cfla_alu.sv =====
// cfla_alu: the one add/subtract unit shared by the steps of the sequencer
// uses cfla_pkg for the operation type
`default_nettype none

module cfla_alu #(
    parameter int ADDR_BITS = cfla_pkg::ADDR_BITS_DEF
) (
    input  wire cfla_pkg::alu_op_t  op,
    input  wire [ADDR_BITS-1:0]     a,
    input  wire [ADDR_BITS-1:0]     b,
    output logic [ADDR_BITS-1:0]    result,
    output logic                    carry     // carry on add, borrow (a < b) on subtract
);

    logic [ADDR_BITS:0] wide;

    // one extra bit gives carry or borrow
    always_comb begin
        unique case (op)
            cfla_pkg::ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            cfla_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default:           wide = '0;
        endcase
    end

    assign result = wide[ADDR_BITS-1:0];
    assign carry  = wide[ADDR_BITS];

endmodule

`default_nettype wire

// ===== hdl/coalescing_free_list_allocator.sv =====
// coalescing_free_list_allocator: first-fit allocator over a sorted free-region table
// depends on cfla_pkg and cfla_alu
//
//  channel   dir  signals                      content
//  s_        in   s_tvalid s_tready s_tdata     tdata: block_offset, block_length
//                 s_tuser                       tuser: mode (0 allocate, 1 free)
//  m_        out  m_tvalid m_tready m_tdata     tdata: granted_offset, status, region_count
//  cfg_      in   cfg_wr_en cfg_wr_data         arena_size, rebuilds the table
//
// an allocate scans to find a region and may then close a gap;
// a free searches and merges, and may then open a slot or close a gap
// both walks run one table entry per cycle through the one-read, one-write region memory
// reset loads entry 0 with the arena during the reset cycle itself; no clearing pass
// the block accepts a new beat while a finished result waits on m_, and holds
// the finished result in its response state while the output register is full
`default_nettype none

module coalescing_free_list_allocator #(
    parameter int MAX_REGIONS = cfla_pkg::MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = cfla_pkg::ADDR_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // request beats
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire [cfla_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] block_offset, [63:32] block_length
    input  wire                             s_tuser,   // [0] mode
    // result beats
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [cfla_pkg::M_TDATA_W-1:0]  m_tdata,   // [31:0] granted_offset, [33:32] status,
                                                       // [40:34] region_count, [47:41] zero
    // arena size register
    input  wire                             cfg_wr_en,
    input  wire [cfla_pkg::FIELD_W-1:0]     cfg_wr_data
);

    localparam int CW   = $clog2(MAX_REGIONS + 1);
    localparam int AWID = $clog2(MAX_REGIONS);
    localparam int FW   = cfla_pkg::FIELD_W;

    localparam logic [ADDR_BITS-1:0] ARENA_INIT = ADDR_BITS'(cfla_pkg::ARENA_RESET);
    localparam logic [ADDR_BITS-1:0] ADDR_ONES  = '1;
    localparam logic [CW-1:0]        N_INIT     = (ARENA_INIT != '0) ? CW'(1) : CW'(0);
    localparam logic [CW-1:0]        N_MAX      = CW'(MAX_REGIONS);

    // region table memory
    logic [ADDR_BITS-1:0] start_mem [MAX_REGIONS];
    logic [ADDR_BITS-1:0] len_mem   [MAX_REGIONS];

    logic                 rd_en;
    logic [AWID-1:0]      rd_addr;
    logic [ADDR_BITS-1:0] rd_start_reg, rd_len_reg;
    logic                 wr_en;
    logic [AWID-1:0]      wr_addr;
    logic [ADDR_BITS-1:0] wr_start, wr_len;
    logic [ADDR_BITS-1:0] rebuild_len;

    // sequencer state
    cfla_pkg::state_t     state_reg, state_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        ptr_reg, ptr_next;

    // request and working values
    logic [ADDR_BITS-1:0] off_reg, off_next;
    logic [ADDR_BITS-1:0] len_reg, len_next;
    logic [ADDR_BITS-1:0] end_reg, end_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [ADDR_BITS-1:0] cur_len_reg, cur_len_next;
    logic [ADDR_BITS-1:0] prev_start_reg, prev_start_next;
    logic [ADDR_BITS-1:0] prev_len_reg, prev_len_next;
    logic [ADDR_BITS-1:0] prev_end_reg, prev_end_next;
    logic [ADDR_BITS-1:0] sum_reg, sum_next;
    logic [ADDR_BITS-1:0] granted_reg, granted_next;
    cfla_pkg::status_t    status_reg, status_next;

    // output register
    logic                            m_valid_reg, m_valid_next;
    logic [cfla_pkg::M_TDATA_W-1:0]  m_data_reg, m_data_next;

    // shared adder
    cfla_pkg::alu_op_t    alu_op;
    logic [ADDR_BITS-1:0] alu_a, alu_b, alu_res;
    logic                 alu_carry;

    cfla_alu #(
        .ADDR_BITS (ADDR_BITS)
    ) u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_res),
        .carry  (alu_carry)
    );

    // decode helpers
    logic [ADDR_BITS-1:0] in_off, in_len;
    logic [CW-1:0]        scan_inc, ptr_inc, ptr_inc2, ptr_dec, ptr_dec2, pos_dec, n_dec;
    logic                 n_zero, scan_last, table_full, at_tail, prev_adj, next_adj;
    logic                 out_free;

    assign in_off      = ADDR_BITS'(s_tdata[FW-1:0]);
    assign in_len      = ADDR_BITS'(s_tdata[2*FW-1:FW]);
    assign rebuild_len = ADDR_BITS'(cfg_wr_data);
    assign scan_inc    = scan_reg + CW'(1);
    assign ptr_inc     = ptr_reg + CW'(1);
    assign ptr_inc2    = ptr_reg + CW'(2);
    assign ptr_dec     = ptr_reg - CW'(1);
    assign ptr_dec2    = ptr_reg - CW'(2);
    assign pos_dec     = pos_reg - CW'(1);
    assign n_dec       = n_reg - CW'(1);
    assign n_zero      = (n_reg == '0);
    assign scan_last   = (scan_inc == n_reg);
    assign table_full  = (n_reg == N_MAX);
    assign at_tail     = (pos_reg == n_reg);
    assign prev_adj    = (prev_end_reg == off_reg);
    assign next_adj    = !at_tail && (cur_start_reg == end_reg);
    assign out_free    = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == cfla_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cfla_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == cfla_pkg::MODE_FREE) begin
                        state_next = (in_len == '0) ? cfla_pkg::ST_RESP : cfla_pkg::ST_F_END;
                    end else begin
                        state_next = n_zero ? cfla_pkg::ST_RESP : cfla_pkg::ST_A_SCAN;
                    end
                end
            end
            cfla_pkg::ST_A_SCAN: begin
                if (!alu_carry) begin
                    state_next = cfla_pkg::ST_A_UPD;
                end else if (scan_last) begin
                    state_next = cfla_pkg::ST_RESP;
                end
            end
            cfla_pkg::ST_A_UPD: begin
                state_next = (sum_reg == '0) ? cfla_pkg::ST_DN_START : cfla_pkg::ST_RESP;
            end
            cfla_pkg::ST_F_END: begin
                state_next = n_zero ? cfla_pkg::ST_UP_START : cfla_pkg::ST_F_SCAN;
            end
            cfla_pkg::ST_F_SCAN: begin
                if (alu_carry) begin
                    if (scan_last) begin
                        state_next = cfla_pkg::ST_F_PEND;
                    end
                end else if (scan_reg == '0) begin
                    state_next = cfla_pkg::ST_F_HEAD;
                end else begin
                    state_next = cfla_pkg::ST_F_PEND;
                end
            end
            cfla_pkg::ST_F_HEAD: begin
                state_next = (cur_start_reg == end_reg) ? cfla_pkg::ST_RESP
                                                        : cfla_pkg::ST_UP_START;
            end
            cfla_pkg::ST_F_PEND: begin
                state_next = cfla_pkg::ST_F_DECIDE;
            end
            cfla_pkg::ST_F_DECIDE: begin
                if (prev_adj) begin
                    state_next = next_adj ? cfla_pkg::ST_F_MERGE3 : cfla_pkg::ST_RESP;
                end else if (next_adj) begin
                    state_next = cfla_pkg::ST_RESP;
                end else begin
                    state_next = cfla_pkg::ST_UP_START;
                end
            end
            cfla_pkg::ST_F_MERGE3: begin
                state_next = cfla_pkg::ST_DN_START;
            end
            cfla_pkg::ST_DN_START: begin
                state_next = (ptr_inc == n_reg) ? cfla_pkg::ST_RESP : cfla_pkg::ST_DN_WR;
            end
            cfla_pkg::ST_DN_WR: begin
                if (ptr_inc2 == n_reg) begin
                    state_next = cfla_pkg::ST_RESP;
                end
            end
            cfla_pkg::ST_UP_START: begin
                if (table_full) begin
                    state_next = cfla_pkg::ST_RESP;
                end else if (at_tail) begin
                    state_next = cfla_pkg::ST_UP_FIN;
                end else begin
                    state_next = cfla_pkg::ST_UP_WR;
                end
            end
            cfla_pkg::ST_UP_WR: begin
                if (ptr_dec == pos_reg) begin
                    state_next = cfla_pkg::ST_UP_FIN;
                end
            end
            cfla_pkg::ST_UP_FIN: begin
                state_next = cfla_pkg::ST_RESP;
            end
            cfla_pkg::ST_RESP: begin
                if (out_free) begin
                    state_next = cfla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cfla_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control: adder operands, memory ports and register updates
    always_comb begin
        alu_op          = cfla_pkg::ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_start        = '0;
        wr_len          = '0;
        n_next          = n_reg;
        scan_next       = scan_reg;
        pos_next        = pos_reg;
        ptr_next        = ptr_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        end_next        = end_reg;
        cur_start_next  = cur_start_reg;
        cur_len_next    = cur_len_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        prev_end_next   = prev_end_reg;
        sum_next        = sum_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            cfla_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    off_next    = in_off;
                    len_next    = in_len;
                    status_next = cfla_pkg::STATUS_OK;
                    scan_next   = '0;
                    if (s_tuser == cfla_pkg::MODE_FREE) begin
                        granted_next = '0;
                    end else if (n_zero) begin
                        granted_next = ADDR_ONES;
                        status_next  = cfla_pkg::STATUS_NO_FIT;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            // first fit: length minus request, no borrow means it fits
            cfla_pkg::ST_A_SCAN: begin
                alu_op = cfla_pkg::ALU_SUB;
                alu_a  = rd_len_reg;
                alu_b  = len_reg;
                if (!alu_carry) begin
                    cur_start_next = rd_start_reg;
                    granted_next   = rd_start_reg;
                    sum_next       = alu_res;
                end else if (scan_last) begin
                    granted_next = ADDR_ONES;
                    status_next  = cfla_pkg::STATUS_NO_FIT;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_inc[AWID-1:0];
                    scan_next = scan_inc;
                end
            end
            // shrink the region from its front, or drop it when empty
            cfla_pkg::ST_A_UPD: begin
                alu_a = cur_start_reg;
                alu_b = len_reg;
                if (sum_reg == '0) begin
                    ptr_next = scan_reg;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = scan_reg[AWID-1:0];
                    wr_start = alu_res;
                    wr_len   = sum_reg;
                end
            end
            cfla_pkg::ST_F_END: begin
                alu_a    = off_reg;
                alu_b    = len_reg;
                end_next = alu_res;
                pos_next = '0;
                if (!n_zero) begin
                    rd_en = 1'b1;
                end
            end
            // lower-bound search: stop at the first start not below the offset
            cfla_pkg::ST_F_SCAN: begin
                alu_op = cfla_pkg::ALU_SUB;
                alu_a  = rd_start_reg;
                alu_b  = off_reg;
                if (alu_carry) begin
                    prev_start_next = rd_start_reg;
                    prev_len_next   = rd_len_reg;
                    if (scan_last) begin
                        pos_next = n_reg;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = scan_inc[AWID-1:0];
                        scan_next = scan_inc;
                    end
                end else begin
                    cur_start_next = rd_start_reg;
                    cur_len_next   = rd_len_reg;
                    pos_next       = scan_reg;
                end
            end
            // block lands ahead of the first region
            cfla_pkg::ST_F_HEAD: begin
                alu_a = cur_len_reg;
                alu_b = len_reg;
                if (cur_start_reg == end_reg) begin
                    wr_en    = 1'b1;
                    wr_start = off_reg;
                    wr_len   = alu_res;
                end
            end
            cfla_pkg::ST_F_PEND: begin
                alu_a         = prev_start_reg;
                alu_b         = prev_len_reg;
                prev_end_next = alu_res;
            end
            // merge with previous, next, both, or fall through to insert
            cfla_pkg::ST_F_DECIDE: begin
                if (prev_adj) begin
                    alu_a = prev_len_reg;
                    alu_b = len_reg;
                    if (next_adj) begin
                        sum_next = alu_res;
                    end else begin
                        wr_en    = 1'b1;
                        wr_addr  = pos_dec[AWID-1:0];
                        wr_start = prev_start_reg;
                        wr_len   = alu_res;
                    end
                end else if (next_adj) begin
                    alu_a    = cur_len_reg;
                    alu_b    = len_reg;
                    wr_en    = 1'b1;
                    wr_addr  = pos_reg[AWID-1:0];
                    wr_start = off_reg;
                    wr_len   = alu_res;
                end
            end
            cfla_pkg::ST_F_MERGE3: begin
                alu_a    = sum_reg;
                alu_b    = cur_len_reg;
                wr_en    = 1'b1;
                wr_addr  = pos_dec[AWID-1:0];
                wr_start = prev_start_reg;
                wr_len   = alu_res;
                ptr_next = pos_reg;
            end
            // close the gap at ptr: entries above move down one
            cfla_pkg::ST_DN_START: begin
                if (ptr_inc == n_reg) begin
                    n_next = n_dec;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_inc[AWID-1:0];
                end
            end
            cfla_pkg::ST_DN_WR: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AWID-1:0];
                wr_start = rd_start_reg;
                wr_len   = rd_len_reg;
                if (ptr_inc2 == n_reg) begin
                    n_next = n_dec;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_inc2[AWID-1:0];
                    ptr_next = ptr_inc;
                end
            end
            // open a slot at pos: entries from the top move up one
            cfla_pkg::ST_UP_START: begin
                if (table_full) begin
                    status_next = cfla_pkg::STATUS_FULL;
                end else if (!at_tail) begin
                    rd_en    = 1'b1;
                    rd_addr  = n_dec[AWID-1:0];
                    ptr_next = n_reg;
                end
            end
            cfla_pkg::ST_UP_WR: begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AWID-1:0];
                wr_start = rd_start_reg;
                wr_len   = rd_len_reg;
                if (ptr_dec != pos_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_dec2[AWID-1:0];
                    ptr_next = ptr_dec;
                end
            end
            cfla_pkg::ST_UP_FIN: begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg[AWID-1:0];
                wr_start = off_reg;
                wr_len   = len_reg;
                n_next   = n_reg + CW'(1);
            end
            // hand the result to the output register
            cfla_pkg::ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{cfla_pkg::M_PAD_W{1'b0}}, cfla_pkg::COUNT_W'(n_reg),
                                    status_reg, FW'(granted_reg)};
                end
            end
            default: begin
            end
        endcase

        // arena write rebuilds the table as one region, or as none when the size is zero
        if (cfg_wr_en) begin
            n_next = (rebuild_len != '0) ? CW'(1) : CW'(0);
        end
    end

    // region memory: entry 0 is reloaded on reset and on an arena write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mem[0] <= '0;
            len_mem[0]   <= ARENA_INIT;
        end else if (cfg_wr_en) begin
            start_mem[0] <= '0;
            len_mem[0]   <= rebuild_len;
        end else if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            len_mem[wr_addr]   <= wr_len;
        end
        if (rd_en) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_len_reg   <= len_mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cfla_pkg::ST_IDLE;
            n_reg       <= N_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        scan_reg       <= scan_next;
        pos_reg        <= pos_next;
        ptr_reg        <= ptr_next;
        off_reg        <= off_next;
        len_reg        <= len_next;
        end_reg        <= end_next;
        cur_start_reg  <= cur_start_next;
        cur_len_reg    <= cur_len_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        prev_end_reg   <= prev_end_next;
        sum_reg        <= sum_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        m_data_reg     <= m_data_next;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= N_MAX)
        else $error("region count above table depth");

    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in progress");

    a_full_needs_full_table: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[FW+cfla_pkg::STATUS_W-1:FW] == cfla_pkg::STATUS_FULL)
        |-> m_tdata[FW+cfla_pkg::STATUS_W+cfla_pkg::COUNT_W-1:FW+cfla_pkg::STATUS_W]
            == cfla_pkg::COUNT_W'(MAX_REGIONS))
        else $error("table-full status with spare entries");

    a_no_fit_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[FW+cfla_pkg::STATUS_W-1:FW] == cfla_pkg::STATUS_NO_FIT)
        |-> m_tdata[FW-1:0] == FW'(ADDR_ONES))
        else $error("no-fit result without all-ones offset");

    a_idle_count_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cfla_pkg::ST_IDLE) && !cfg_wr_en |=> n_reg == $past(n_reg))
        else $error("region count changed while idle");

endmodule

`default_nettype wire
